### rtl/sli_pkg.sv
// Shared types and codes for the sorted list insertion block.
package sli_pkg;

    localparam int VALUE_W = 32;
    localparam int KIND_W  = 3;
    localparam int COUNT_W = 6;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_CLEAR  = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;

    localparam logic [KIND_W-1:0] KIND_INSERTED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CLEARED  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ENTRY    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EMPTY    = 3'd4;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op                   op;
        logic signed [VALUE_W-1:0]  value;
    } t_cell_ctrl;

    typedef struct packed {
        logic [KIND_W-1:0]          kind;
        logic signed [VALUE_W-1:0]  value;
        logic [COUNT_W-1:0]         count;
        logic                       last;
    } t_result;

endpackage

### rtl/sli_cell.sv
// One cell of the sorted chain: holds a single entry and trades it with its neighbors.
module sli_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 6
) (
    input  logic                               i_clk,
    input  sli_pkg::t_cell_ctrl                i_ctrl,
    input  logic [CW-1:0]                      i_count,
    input  logic                               i_prev_take,
    input  logic signed [sli_pkg::VALUE_W-1:0] i_prev_entry,
    input  logic signed [sli_pkg::VALUE_W-1:0] i_next_entry,
    input  logic signed [sli_pkg::VALUE_W-1:0] i_head_entry,
    output logic                               o_take,
    output logic signed [sli_pkg::VALUE_W-1:0] o_entry
);
    import sli_pkg::*;

    logic signed [VALUE_W-1:0] r_entry;
    logic signed [VALUE_W-1:0] n_entry;
    logic                      occupied;
    logic                      at_end;
    logic                      is_tail;

    assign occupied = CW'(INDEX) < i_count;
    assign at_end   = CW'(INDEX) == i_count;
    assign is_tail  = (CW'(INDEX) + CW'(1)) == i_count;
    assign o_take   = (occupied && (r_entry >= i_ctrl.value)) || at_end;
    assign o_entry  = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_ctrl.op)
            CELL_INSERT: begin
                if (o_take) begin
                    n_entry = i_prev_take ? i_prev_entry : i_ctrl.value;
                end
            end
            CELL_ROTATE: begin
                n_entry = is_tail ? i_head_entry : i_next_entry;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

### rtl/sli_outq.sv
// Two-slot result queue that lets the chain keep working while a result waits.
module sli_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sli_pkg::t_result i_data,
    input  logic             i_ready,
    output logic             o_valid,
    output sli_pkg::t_result o_data,
    output logic             o_room
);
    import sli_pkg::*;

    t_result    r_head;
    t_result    r_tail;
    logic [1:0] r_fill;
    t_result    n_head;
    t_result    n_tail;
    logic [1:0] n_fill;
    logic       pop;

    assign pop     = (r_fill != 2'd0) && i_ready;
    assign o_valid = r_fill != 2'd0;
    assign o_data  = r_head;
    assign o_room  = (r_fill != 2'd2) || pop;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_fill = r_fill;
        if (pop) begin
            n_head = r_tail;
            n_fill = r_fill - 2'd1;
        end
        if (i_push) begin
            if (n_fill == 2'd0) begin
                n_head = i_data;
            end else begin
                n_tail = i_data;
            end
            n_fill = n_fill + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_tail <= n_tail;
        if (!i_rst_n) begin
            r_fill <= 2'd0;
        end else begin
            r_fill <= n_fill;
        end
    end

endmodule

### rtl/sorted_list_insert.sv
// Top level of the sorted list insertion block.
// Keeps up to DEPTH signed values in ascending order in a chain of cells, one
// entry per cell. On an insert, every cell compares its entry with the new
// value at once and the tail of the list shifts by one cell. A readout
// sends one stored entry per cycle while the result queue has room, since
// the chain rotates its entries through the first cell, which feeds the
// result port. Results pass through a two-slot queue, so, outside a readout,
// a new request is taken while one result still waits.
module sorted_list_insert #(
    parameter int DEPTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_func,
    input  logic signed [sli_pkg::VALUE_W-1:0] i_new_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [sli_pkg::KIND_W-1:0]         o_kind,
    output logic signed [sli_pkg::VALUE_W-1:0] o_value,
    output logic [sli_pkg::COUNT_W-1:0]        o_count,
    output logic                               o_last
);
    import sli_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic                      r_busy;
    logic                      n_busy;
    logic [IW-1:0]             r_idx;
    logic [IW-1:0]             n_idx;
    logic                      accept;
    logic                      room;
    logic                      full;
    logic                      rd_last;
    logic                      push;
    t_result                   push_data;
    t_result                   out_data;
    t_cell_ctrl                ctrl;
    logic [DEPTH-1:0]          take;
    logic signed [VALUE_W-1:0] entry [DEPTH];

    assign o_in_ready = !r_busy && room;
    assign accept     = i_in_valid && o_in_ready;
    assign full       = r_count == CW'(DEPTH);
    assign rd_last    = (CW'(r_idx) + CW'(1)) == r_count;

    always_comb begin
        n_count    = r_count;
        n_busy     = r_busy;
        n_idx      = r_idx;
        push       = 1'b0;
        push_data  = '{kind: KIND_INSERTED, value: '0, count: COUNT_W'(r_count), last: 1'b1};
        ctrl.op    = CELL_HOLD;
        ctrl.value = i_new_value;
        if (r_busy) begin
            if (room) begin
                push            = 1'b1;
                push_data.kind  = KIND_ENTRY;
                push_data.value = entry[0];
                push_data.last  = rd_last;
                ctrl.op         = CELL_ROTATE;
                n_idx           = r_idx + IW'(1);
                if (rd_last) begin
                    n_busy = 1'b0;
                end
            end
        end else if (accept) begin
            case (i_func)
                FUNC_INSERT: begin
                    push = 1'b1;
                    if (full) begin
                        push_data.kind = KIND_FULL;
                    end else begin
                        ctrl.op         = CELL_INSERT;
                        n_count         = r_count + CW'(1);
                        push_data.count = COUNT_W'(n_count);
                    end
                end
                FUNC_CLEAR: begin
                    push            = 1'b1;
                    n_count         = '0;
                    push_data.kind  = KIND_CLEARED;
                    push_data.count = '0;
                end
                FUNC_READ: begin
                    if (r_count == '0) begin
                        push           = 1'b1;
                        push_data.kind = KIND_EMPTY;
                    end else begin
                        n_busy = 1'b1;
                        n_idx  = '0;
                    end
                end
                default: begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (!i_rst_n) begin
            r_count <= '0;
            r_busy  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_busy  <= n_busy;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        sli_cell #(
            .INDEX (g),
            .CW    (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (ctrl),
            .i_count      (r_count),
            .i_prev_take  ((g == 0) ? 1'b0 : take[(g == 0) ? 0 : g - 1]),
            .i_prev_entry (entry[(g == 0) ? 0 : g - 1]),
            .i_next_entry (entry[(g == DEPTH - 1) ? 0 : g + 1]),
            .i_head_entry (entry[0]),
            .o_take       (take[g]),
            .o_entry      (entry[g])
        );
    end

    sli_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (out_data),
        .o_room  (room)
    );

    assign o_kind  = out_data.kind;
    assign o_value = out_data.value;
    assign o_count = out_data.count;
    assign o_last  = out_data.last;

endmodule
